FILE: rtl/two_class_age_ordered_queue_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define TCAQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define TCAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tcaq_pkg.sv
// Shared types and codes for the two-class age-ordered queue.
package tcaq_pkg;

	typedef enum logic [1:0] {
		MODE_ADD      = 2'd0,
		MODE_POLL_ANY = 2'd1,
		MODE_POLL_C0  = 2'd2,
		MODE_POLL_C1  = 2'd3
	} mode_t;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	localparam logic CLASS_DOG = 1'b0;
	localparam logic CLASS_CAT = 1'b1;

	// Queue control, per class
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	// Queue status, per class
	typedef struct packed {
		logic empty;
		logic full;
		logic one;
	} q_stat_t;

endpackage

FILE: rtl/two_class_age_ordered_queue.sv
// Two-class age-ordered queue: top level with input stage, arbitration and result register.
//
// Usage:
//   Slave channel s_*: one beat is one operation. s_tuser carries the mode
//   (add, poll oldest of either class, poll class 0, poll class 1) and the
//   class of an added item; s_tdata carries the handle to store.
//   Master channel m_*: exactly one result beat per operation, in order.
//   m_tdata carries the polled handle (zero if none), m_tuser the status,
//   the polled class and the three emptiness flags after the operation.
//   An accepted beat moves from the input stage to the result register,
//   which drives m_tvalid. Throughput: one operation per cycle unless the
//   receiver stalls; each operation touches only the two queue heads,
//   tails and the arrival counter; each class RAM sees one write and one read per cycle.
//   Age between the class heads is the wrap-aware difference of their
//   arrival stamps; equal stamps favour class 1.
//   Reset empties both queues and clears the arrival counter; RAM contents
//   are not cleared and no clearing pass is needed.
//   If the receiver stalls, the result register holds its beat and the
//   input stage takes one more beat before s_tready falls.
`include "two_class_age_ordered_queue_macros.svh"

module two_class_age_ordered_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16,
	parameter int SEQ_BITS    = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((HANDLE_BITS+7)/8)*8-1:0]      s_tdata,  // item_handle
	input  logic [2:0]                            s_tuser,  // mode[1:0], item_class
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((HANDLE_BITS+7)/8)*8-1:0]      m_tdata,  // out_handle
	output logic [5:0]                            m_tuser   // status[1:0], out_class,
	                                                        // all_empty, class0_empty,
	                                                        // class1_empty
);
	import tcaq_pkg::*;

	localparam int TDATA_W = ((HANDLE_BITS + 7) / 8) * 8;
	localparam int ENTRY_W = HANDLE_BITS + SEQ_BITS;

	logic                   v_s1;
	mode_t                  mode_s1;
	logic                   cls_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic                   m_tvalid_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [5:0]             m_tuser_q;
	logic [SEQ_BITS-1:0]    seq_q;

	logic                   out_free;
	logic                   adv;
	logic                   accept;

	q_ctl_t                 ctl0, ctl1;
	q_stat_t                st0, st1;
	logic [ENTRY_W-1:0]     head0, head1;
	logic [ENTRY_W-1:0]     wentry;
	logic [SEQ_BITS-1:0]    age_diff;

	logic                   take0, take1;
	status_t                status;
	logic [HANDLE_BITS-1:0] res_handle;
	logic                   res_class;
	logic                   empty0_after, empty1_after;

	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign wentry   = {seq_q, handle_s1};

	tcaq_class_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_q0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl0),
		.wdata     (wentry),
		.head_entry(head0),
		.stat      (st0)
	);

	tcaq_class_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_q1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl1),
		.wdata     (wentry),
		.head_entry(head1),
		.stat      (st1)
	);

	assign age_diff = head0[ENTRY_W-1:HANDLE_BITS] - head1[ENTRY_W-1:HANDLE_BITS];

	always_comb begin
		take0     = 1'b0;
		take1     = 1'b0;
		ctl0.push = 1'b0;
		ctl1.push = 1'b0;
		status    = STATUS_OK;
		unique case (mode_s1)
			MODE_ADD: begin
				if (cls_s1 == CLASS_CAT) begin
					ctl1.push = adv && !st1.full;
					status    = st1.full ? STATUS_FULL : STATUS_OK;
				end else begin
					ctl0.push = adv && !st0.full;
					status    = st0.full ? STATUS_FULL : STATUS_OK;
				end
			end
			MODE_POLL_ANY: begin
				if (!st0.empty && !st1.empty) begin
					take0 = age_diff[SEQ_BITS-1];
					take1 = !age_diff[SEQ_BITS-1];
				end else begin
					take0 = !st0.empty;
					take1 = !st1.empty;
				end
			end
			MODE_POLL_C0: take0 = !st0.empty;
			MODE_POLL_C1: take1 = !st1.empty;
			default: ;
		endcase
		if (mode_s1 != MODE_ADD && !take0 && !take1) begin
			status = STATUS_EMPTY;
		end
		ctl0.pop = adv && take0;
		ctl1.pop = adv && take1;
	end

	assign res_handle   = take0 ? head0[HANDLE_BITS-1:0] :
	                      take1 ? head1[HANDLE_BITS-1:0] : '0;
	assign res_class    = take1 ? CLASS_CAT : CLASS_DOG;
	assign empty0_after = (st0.empty && !ctl0.push) || (st0.one && take0);
	assign empty1_after = (st1.empty && !ctl1.push) || (st1.one && take1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
			seq_q      <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ctl0.push || ctl1.push) begin
				seq_q <= seq_q + SEQ_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(s_tuser[1:0]);
			cls_s1    <= s_tuser[2];
			handle_s1 <= s_tdata[HANDLE_BITS-1:0];
		end
		if (adv) begin
			out_handle_q <= res_handle;
			m_tuser_q    <= {empty1_after, empty0_after, empty0_after && empty1_after,
			                 res_class, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(out_handle_q);
	assign m_tuser  = m_tuser_q;

	`TCAQ_ASSERT_NOW(a_one_pop, clk, arst_n, 1'b1, !(ctl0.pop && ctl1.pop),
		"both classes popped on one beat")
	`TCAQ_ASSERT_NOW(a_no_push_pop, clk, arst_n, ctl0.push || ctl1.push,
		!ctl0.pop && !ctl1.pop, "push and pop on one beat")
	`TCAQ_ASSERT_NEXT(a_seq_step, clk, arst_n, ctl0.push || ctl1.push,
		seq_q == $past(seq_q) + SEQ_BITS'(1), "arrival counter did not advance")
	`TCAQ_ASSERT_NEXT(a_full_keeps_seq, clk, arst_n, adv && status == STATUS_FULL,
		seq_q == $past(seq_q), "rejected add advanced the counter")

endmodule

FILE: rtl/tcaq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcaq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/tcaq_class_fifo.sv
// One class queue: RAM-backed FIFO that always presents its head entry.
`include "two_class_age_ordered_queue_macros.svh"

module tcaq_class_fifo #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcaq_pkg::q_ctl_t  ctl,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  head_entry,
	output tcaq_pkg::q_stat_t stat
);
	import tcaq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0]    head_q;
	logic [IW-1:0]    tail_q;
	logic [CW-1:0]    fill_q;
	logic [IW-1:0]    head_d;
	logic             do_push;
	logic             do_pop;
	logic [WIDTH-1:0] rdata;
	logic             byp_q;
	logic [WIDTH-1:0] byp_data_q;

	function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
	endfunction

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CW'(DEPTH));
	assign stat.one   = (fill_q == CW'(1));

	assign do_push = ctl.push && !stat.full;
	assign do_pop  = ctl.pop && !stat.empty;
	assign head_d  = do_pop ? ptr_inc(head_q) : head_q;

	// Read address tracks the next head; a write landing there is bypassed
	tcaq_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (do_push),
		.waddr(tail_q),
		.wdata(wdata),
		.raddr(head_d),
		.rdata(rdata)
	);

	assign head_entry = byp_q ? byp_data_q : rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			byp_q  <= do_push && (tail_q == head_d);
			if (do_push) begin
				tail_q <= ptr_inc(tail_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wdata;
	end

	`TCAQ_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(DEPTH), "fill over depth")
	`TCAQ_ASSERT_NEXT(a_full_hold, clk, arst_n, stat.full && ctl.push && !ctl.pop,
		fill_q == $past(fill_q), "push into full queue changed fill")
	`TCAQ_ASSERT_NEXT(a_pop_head, clk, arst_n, do_pop && !do_push,
		head_q != $past(head_q) || DEPTH == 1, "pop did not advance head")

endmodule
